@@ hdl/ptm_pkg.sv @@
`timescale 1ns / 1ps
package ptm_pkg;

    localparam int IDX_W   = 9;
    localparam int VPN_W   = 36;
    localparam int PPN_W   = 40;
    localparam int ENTRY_W = 64;
    localparam int USED_W  = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SIZE  = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    localparam logic [ENTRY_W-1:0] PE_PRESENT = 64'h0000_0000_0000_0001;
    localparam logic [ENTRY_W-1:0] PE_WRITE   = 64'h0000_0000_0000_0002;
    localparam logic [ENTRY_W-1:0] PE_USER    = 64'h0000_0000_0000_0004;
    localparam logic [ENTRY_W-1:0] PE_LARGE   = 64'h0000_0000_0000_0080;
    localparam logic [ENTRY_W-1:0] PE_NOEXEC  = 64'h8000_0000_0000_0000;

    // walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic       clr_en;
        logic       rd_en;
        logic       eval_en;
        logic       leaf_en;
        logic       out_load;
        logic [1:0] lvl;
    } ptm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic stop;
        logic out_free;
    } ptm_sts_t;

endpackage

@@ hdl/ptm_ctrl.sv @@
`timescale 1ns / 1ps
module ptm_ctrl
    import ptm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output ptm_cmd_t cmd,
    input  ptm_sts_t sts
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] lvl_reg, lvl_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            lvl_reg   <= LVL_PML4;
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        cmd          = '0;
        cmd.lvl      = lvl_reg;
        s_tready     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    lvl_next    = LVL_PML4;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval_en = 1'b1;
                if (sts.stop) begin
                    state_next = S_FIN;
                end else if (lvl_reg == LVL_PD) begin
                    // page table leaf is written without a read
                    lvl_next   = LVL_PT;
                    state_next = S_LEAF;
                end else begin
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_READ;
                end
            end
            S_LEAF: begin
                cmd.leaf_en = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/ptm_dpath.sv @@
`timescale 1ns / 1ps
module ptm_dpath
    import ptm_pkg::*;
#(
    parameter int POOL_PAGES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [79:0]         s_tdata,
    input  logic                cfg_valid,
    input  logic [PPN_W-1:0]    cfg_data,
    input  ptm_cmd_t            cmd,
    output ptm_sts_t            sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata
);

    localparam int SW    = $clog2(POOL_PAGES);
    localparam int NW    = $clog2(POOL_PAGES + 1);
    localparam int AW    = SW + IDX_W;
    localparam int DEPTH = POOL_PAGES * 512;
    localparam int LAST  = DEPTH - 1;

    // word = {written after its slot was allocated, entry}
    logic [ENTRY_W:0] mem [DEPTH];

    logic [VPN_W-1:0]   virt_reg;
    logic [PPN_W-1:0]   phys_reg;
    logic               large_reg;
    logic [1:0]         rights_reg;
    logic               user_reg;
    logic [PPN_W-1:0]   base_reg;
    logic [NW-1:0]      nf_reg;
    logic [SW-1:0]      cur_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [ENTRY_W:0]   rdata_reg;
    logic               rd_alloc_reg;
    logic [1:0]         st_reg;
    logic [ENTRY_W-1:0] leaf_reg;
    logic               m_tvalid_reg;
    logic [1:0]         m_status_reg;
    logic [ENTRY_W-1:0] m_leaf_reg;
    logic [USED_W-1:0]  m_used_reg;

    logic [IDX_W-1:0]   idx;
    logic [AW-1:0]      walk_addr;
    logic               cur_alloc;
    logic [ENTRY_W-1:0] e;
    logic [51:0]        diff;
    logic               in_pool;
    logic               full;
    logic [PPN_W-1:0]   new_ppn;
    logic [ENTRY_W-1:0] new_tbl;
    logic [ENTRY_W-1:0] user_bits;
    logic [ENTRY_W-1:0] leaf;
    logic               ev_stop;
    logic [1:0]         ev_st;
    logic               ev_wr;
    logic [ENTRY_W-1:0] ev_wdata;
    logic               ev_alloc;
    logic               ev_follow;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W:0]   wr_data;

    always_comb begin
        case (cmd.lvl)
            LVL_PML4: idx = virt_reg[35:27];
            LVL_PDPT: idx = virt_reg[26:18];
            LVL_PD:   idx = virt_reg[17:9];
            default:  idx = virt_reg[8:0];
        endcase
    end

    assign walk_addr = {cur_reg, idx};
    assign cur_alloc = NW'(cur_reg) < nf_reg;
    assign full      = nf_reg >= NW'(POOL_PAGES);

    // an entry of an allocated table not written since allocation reads as zero
    assign e = (rd_alloc_reg && !rdata_reg[ENTRY_W]) ? '0 : rdata_reg[ENTRY_W-1:0];

    assign diff    = {1'b0, e[62:12]} - {12'b0, base_reg};
    assign in_pool = !diff[51] && (diff[50:0] < 51'(POOL_PAGES));

    assign new_ppn   = base_reg + PPN_W'(nf_reg);
    assign user_bits = user_reg ? PE_USER : '0;
    assign new_tbl   = {12'b0, new_ppn, 12'b0} | PE_PRESENT | PE_WRITE | user_bits;
    assign leaf      = {12'b0, phys_reg, 12'b0} | PE_PRESENT | user_bits
                     | (rights_reg[0] ? PE_WRITE : '0)
                     | (rights_reg[1] ? '0 : PE_NOEXEC);

    always_comb begin
        ev_stop   = 1'b0;
        ev_st     = ST_OK;
        ev_wr     = 1'b0;
        ev_wdata  = new_tbl;
        ev_alloc  = 1'b0;
        ev_follow = 1'b0;
        if (cmd.lvl == LVL_PD && large_reg) begin
            ev_stop = 1'b1;
            if (e != '0 && !e[7]) begin
                ev_st = ST_SIZE;
            end else begin
                ev_wr    = 1'b1;
                ev_wdata = leaf | PE_LARGE;
            end
        end else if (cmd.lvl == LVL_PD && e[7]) begin
            ev_stop = 1'b1;
            ev_st   = ST_SIZE;
        end else if (e == '0) begin
            if (full) begin
                ev_stop = 1'b1;
                ev_st   = ST_NOMEM;
            end else begin
                ev_wr    = 1'b1;
                ev_alloc = 1'b1;
            end
        end else if (in_pool) begin
            ev_follow = 1'b1;
        end else begin
            ev_stop = 1'b1;
            ev_st   = ST_SIZE;
        end
    end

    assign we      = cmd.clr_en || (cmd.eval_en && ev_wr) || cmd.leaf_en;
    assign wr_addr = cmd.clr_en ? clr_addr_reg : walk_addr;
    always_comb begin
        if (cmd.clr_en)       wr_data = '0;
        else if (cmd.leaf_en) wr_data = {cur_alloc, leaf};
        else                  wr_data = {cur_alloc, ev_wdata};
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (cmd.rd_en) rdata_reg <= mem[walk_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) rd_alloc_reg <= cur_alloc;
        if (cmd.load_in) begin
            virt_reg   <= s_tdata[35:0];
            phys_reg   <= s_tdata[75:36];
            large_reg  <= s_tdata[76];
            rights_reg <= s_tdata[78:77];
            user_reg   <= s_tdata[79];
        end
        if (cmd.out_load) begin
            m_status_reg <= st_reg;
            m_leaf_reg   <= leaf_reg;
            m_used_reg   <= USED_W'(nf_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            nf_reg       <= NW'(1);
            cur_reg      <= '0;
            clr_addr_reg <= '0;
            st_reg       <= ST_OK;
            leaf_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) base_reg <= cfg_data;
            if (cmd.clr_en) clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.load_in) begin
                cur_reg  <= '0;
                st_reg   <= ST_OK;
                leaf_reg <= '0;
            end
            if (cmd.eval_en) begin
                if (ev_alloc) begin
                    cur_reg <= SW'(nf_reg);
                    nf_reg  <= nf_reg + NW'(1);
                end else if (ev_follow) begin
                    cur_reg <= diff[SW-1:0];
                end
                if (ev_stop) begin
                    st_reg   <= ev_st;
                    leaf_reg <= (ev_st == ST_OK) ? ev_wdata : '0;
                end
            end
            if (cmd.leaf_en) begin
                st_reg   <= ST_OK;
                leaf_reg <= leaf;
            end
            if (cmd.out_load)          m_tvalid_reg <= 1'b1;
            else if (m_tready)         m_tvalid_reg <= 1'b0;
        end
    end

    assign sts.clr_last = clr_addr_reg == AW'(LAST);
    assign sts.stop     = ev_stop;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_used_reg, m_leaf_reg, m_status_reg};

endmodule

@@ hdl/four_level_page_table_mapper_core.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake               Payload
// s_       in   s_tvalid / s_tready     map request (s_tdata)
// m_       out  m_tvalid / m_tready     result (m_tdata)
// cfg_     in   cfg_valid / cfg_ready   pool_base_page (cfg_data)
//
// After reset a clearing pass zeroes the table store, with s_tready low;
// cfg writes are taken at any time.
// After accept, m_tvalid rises following a read and an evaluate step per
// level (PML4, PDPT, PD) until the walk stops, the PT leaf write for a small
// map, then the result load. s_tready returns the cycle after the load; a
// held result stalls only that load.
module four_level_page_table_mapper_core
    import ptm_pkg::*;
#(
    parameter int POOL_PAGES = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // virt_page[35:0], phys_page[75:36], large_page[76], access_rights[78:77],
    // user_page[79]
    input  logic [79:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[1:0], leaf_entry[65:2], tables_used[70:66], zero pad[71]
    output logic [71:0]      m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PPN_W-1:0] cfg_data
);

    ptm_cmd_t cmd;
    ptm_sts_t sts;

    assign cfg_ready = 1'b1;

    ptm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ptm_dpath #(
        .POOL_PAGES (POOL_PAGES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken item");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[65:2] == '0))
        else $error("nonzero leaf on failed map");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en || cmd.eval_en || cmd.clr_en) |-> !s_tready)
        else $error("input ready while walking or clearing");

endmodule
